FILE: hdl/xcfd_pkg.sv
// shared types and codes of the frame deframer
package xcfd_pkg;

  localparam int BYTE_W   = 8;
  localparam int LEN_W    = 7;
  localparam int STATUS_W = 3;
  localparam int CFG_IDX_W = 1;

  localparam logic [STATUS_W-1:0] ST_DATA      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_CHECK_ERR = 3'd2;
  localparam logic [STATUS_W-1:0] ST_BAD_TAIL  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_TOO_BIG   = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_HEAD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TAIL = 1'b1;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [LEN_W-1:0]    len;
  } cmd_t;

  typedef struct packed {
    logic             en;
    logic [LEN_W-1:0] addr;
    logic [BYTE_W-1:0] data;
  } mem_wr_t;

endpackage

FILE: hdl/xcfd_front.sv
// front end: frame parser, payload write and command push
module xcfd_front #(
  parameter int MAX_PAYLOAD = 64
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_tvalid,
  output logic                    in_tready,
  input  logic [7:0]              in_tdata,
  input  logic [7:0]              head_byte,
  input  logic [7:0]              tail_byte,
  input  logic                    mem_busy,
  input  logic                    q_full,
  output logic                    q_push,
  output xcfd_pkg::cmd_t          q_cmd,
  output xcfd_pkg::mem_wr_t       mem_wr
);
  import xcfd_pkg::*;

  localparam logic [2:0] PH_HUNT  = 3'd0;
  localparam logic [2:0] PH_LEN   = 3'd1;
  localparam logic [2:0] PH_DATA  = 3'd2;
  localparam logic [2:0] PH_CHECK = 3'd3;
  localparam logic [2:0] PH_TAIL  = 3'd4;
  localparam logic [BYTE_W-1:0] MAX_B = BYTE_W'(MAX_PAYLOAD);

  logic [2:0]        phase_r, phase_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [LEN_W-1:0]  cnt_r, cnt_nxt;
  logic [BYTE_W-1:0] xor_r, xor_nxt;
  logic [BYTE_W-1:0] chk_r, chk_nxt;
  logic              accept;

  assign in_tready = !q_full && !((phase_r == PH_DATA) && mem_busy);
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    phase_nxt   = phase_r;
    len_nxt     = len_r;
    cnt_nxt     = cnt_r;
    xor_nxt     = xor_r;
    chk_nxt     = chk_r;
    q_push      = 1'b0;
    q_cmd       = '{status: ST_DATA, len: len_r};
    mem_wr.en   = 1'b0;
    mem_wr.addr = cnt_r;
    mem_wr.data = in_tdata;
    if (accept) begin
      case (phase_r)
        PH_LEN: begin
          if (in_tdata > MAX_B) begin
            q_push       = 1'b1;
            q_cmd.status = ST_TOO_BIG;
            phase_nxt    = PH_HUNT;
          end else begin
            len_nxt   = in_tdata[LEN_W-1:0];
            cnt_nxt   = '0;
            xor_nxt   = '0;
            phase_nxt = (in_tdata == '0) ? PH_CHECK : PH_DATA;
          end
        end
        PH_DATA: begin
          mem_wr.en = 1'b1;
          xor_nxt   = xor_r ^ in_tdata;
          cnt_nxt   = cnt_r + LEN_W'(1);
          if (cnt_nxt >= len_r) begin
            phase_nxt = PH_CHECK;
          end
        end
        PH_CHECK: begin
          chk_nxt   = in_tdata;
          phase_nxt = PH_TAIL;
        end
        PH_TAIL: begin
          q_push = 1'b1;
          if (in_tdata != tail_byte) begin
            q_cmd.status = ST_BAD_TAIL;
          end else if (chk_r != xor_r) begin
            q_cmd.status = ST_CHECK_ERR;
          end else if (len_r == '0) begin
            q_cmd.status = ST_EMPTY;
          end else begin
            q_cmd.status = ST_DATA;
          end
          phase_nxt = PH_HUNT;
        end
        default: begin
          phase_nxt = (in_tdata == head_byte) ? PH_LEN : PH_HUNT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      len_r   <= '0;
      cnt_r   <= '0;
      xor_r   <= '0;
      chk_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      len_r   <= len_nxt;
      cnt_r   <= cnt_nxt;
      xor_r   <= xor_nxt;
      chk_r   <= chk_nxt;
    end
  end

endmodule

FILE: hdl/xcfd_queue.sv
// two-entry command queue between front and back
module xcfd_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  xcfd_pkg::cmd_t push_cmd,
  input  logic           pop,
  output xcfd_pkg::cmd_t pop_cmd,
  output logic           not_empty,
  output logic           full
);
  import xcfd_pkg::*;

  cmd_t       slot_r [2];
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  assign full      = (cnt_r == 2'd2);
  assign not_empty = (cnt_r != 2'd0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_cmd   = slot_r[rp_r];

  always_comb begin
    wp_nxt  = do_push ? !wp_r : wp_r;
    rp_nxt  = do_pop ? !rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wp_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

FILE: hdl/xcfd_back.sv
// back end: payload buffer, result sequencer and output register
module xcfd_back #(
  parameter int MAX_PAYLOAD = 64
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    q_valid,
  input  xcfd_pkg::cmd_t          q_cmd,
  output logic                    q_pop,
  input  xcfd_pkg::mem_wr_t       mem_wr,
  output logic                    busy,
  output logic                    out_tvalid,
  input  logic                    out_tready,
  output logic [7:0]              out_tdata,
  output logic                    out_tlast,
  output logic [2:0]              out_tuser
);
  import xcfd_pkg::*;

  localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam logic [1:0] B_IDLE = 2'd0;
  localparam logic [1:0] B_READ = 2'd1;
  localparam logic [1:0] B_EMIT = 2'd2;

  logic [BYTE_W-1:0] mem [MAX_PAYLOAD];
  logic [BYTE_W-1:0] rd_data_r;
  logic [1:0]        st_r, st_nxt;
  cmd_t              cmd_r, cmd_nxt;
  logic [LEN_W-1:0]  idx_r, idx_nxt;
  logic              ov_r, ov_nxt;
  logic [7:0]        od_r, od_nxt;
  logic              ol_r, ol_nxt;
  logic [2:0]        ou_r, ou_nxt;
  logic              load, single, is_last;

  assign busy       = (st_r != B_IDLE);
  assign q_pop      = q_valid && (st_r == B_IDLE);
  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;
  assign out_tlast  = ol_r;
  assign out_tuser  = ou_r;

  always_ff @(posedge clk) begin
    if (mem_wr.en) begin
      mem[mem_wr.addr[AW-1:0]] <= mem_wr.data;
    end
    rd_data_r <= mem[idx_r[AW-1:0]];
  end

  always_comb begin
    single  = (cmd_r.status != ST_DATA);
    is_last = single || ((idx_r + LEN_W'(1)) == cmd_r.len);
    load    = (st_r == B_EMIT) && (!ov_r || out_tready);
    st_nxt  = st_r;
    cmd_nxt = cmd_r;
    idx_nxt = idx_r;
    ov_nxt  = ov_r && !out_tready;
    od_nxt  = od_r;
    ol_nxt  = ol_r;
    ou_nxt  = ou_r;
    case (st_r)
      B_IDLE: begin
        if (q_valid) begin
          cmd_nxt = q_cmd;
          idx_nxt = '0;
          st_nxt  = (q_cmd.status == ST_DATA) ? B_READ : B_EMIT;
        end
      end
      B_READ: begin
        st_nxt = B_EMIT;
      end
      B_EMIT: begin
        if (load) begin
          ov_nxt  = 1'b1;
          od_nxt  = single ? '0 : rd_data_r;
          ol_nxt  = is_last;
          ou_nxt  = cmd_r.status;
          idx_nxt = idx_r + LEN_W'(1);
          st_nxt  = is_last ? B_IDLE : B_READ;
        end
      end
      default: begin
        st_nxt = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= B_IDLE;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    idx_r <= idx_nxt;
    od_r  <= od_nxt;
    ol_r  <= ol_nxt;
    ou_r  <= ou_nxt;
  end

endmodule

FILE: hdl/xor_checked_frame_deframer_top.sv
// Frame deframer for head, length, payload, xor check, tail frames. The front
// parser takes one received byte per cycle while hunting and for the length,
// check and tail bytes, as long as the command queue has room; payload bytes
// of a new frame are held off while the back end still drains an earlier
// frame from the shared payload buffer. After the tail byte the command goes
// through the command queue to the back end, which gives each payload result
// by a buffer read and then an output register load, holding the load while
// the output is not ready; an error or empty frame result goes straight to
// the output register load. A two-entry command queue lets the parser run
// ahead on short frames.
module xor_checked_frame_deframer_top #(
  parameter int MAX_PAYLOAD = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // rx_byte
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // payload_byte
  output logic       out_tlast,
  output logic [2:0] out_tuser,  // status
  input  logic       cfg_wr_en,
  input  logic [xcfd_pkg::CFG_IDX_W-1:0] cfg_addr,
  input  logic [7:0] cfg_wdata
);
  import xcfd_pkg::*;

  logic [7:0] head_r, tail_r;
  logic       q_push, q_pop, q_not_empty, q_full, back_busy, mem_busy;
  cmd_t       push_cmd, pop_cmd;
  mem_wr_t    mem_wr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        CFG_HEAD: head_r <= cfg_wdata;
        CFG_TAIL: tail_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  assign mem_busy = q_not_empty || back_busy;

  xcfd_front #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .head_byte (head_r),
    .tail_byte (tail_r),
    .mem_busy  (mem_busy),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (push_cmd),
    .mem_wr    (mem_wr)
  );

  xcfd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_cmd  (push_cmd),
    .pop       (q_pop),
    .pop_cmd   (pop_cmd),
    .not_empty (q_not_empty),
    .full      (q_full)
  );

  xcfd_back #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_not_empty),
    .q_cmd      (pop_cmd),
    .q_pop      (q_pop),
    .mem_wr     (mem_wr),
    .busy       (back_busy),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  a_no_write_while_drain: assert property (@(posedge clk) disable iff (!rst_n)
    mem_wr.en |-> !mem_busy) else $error("payload write during drain");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full) else $error("command push into full queue");

  a_single_result_marked: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser != ST_DATA)) |-> (out_tlast && (out_tdata == '0)))
    else $error("status result without last mark or with data");

endmodule
